>>> rtl/pprd_pkg.sv
// Shared types, constants and decode functions for the packed pattern row decoder.
package pprd_pkg;

   localparam int unsigned ROW_COUNT_W = 7;
   localparam logic [ROW_COUNT_W-1:0] ROWS_PER_PATTERN = 7'd64;

   localparam logic [7:0] NOTE_EMPTY   = 8'd255;
   localparam logic [7:0] NOTE_KEY_OFF = 8'd254;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_NOTE    = 2'd1;
   localparam logic [1:0] KIND_KEY_OFF = 2'd2;

   localparam int unsigned CTL_BIT_NOTE = 5;
   localparam int unsigned CTL_BIT_VOL  = 6;
   localparam int unsigned CTL_BIT_CMD  = 7;

   localparam logic [3:0] FX_NONE      = 4'd0;
   localparam logic [3:0] FX_SPEED     = 4'd1;
   localparam logic [3:0] FX_JUMP      = 4'd2;
   localparam logic [3:0] FX_BREAK     = 4'd3;
   localparam logic [3:0] FX_VOLSLIDE  = 4'd4;
   localparam logic [3:0] FX_DOWN      = 4'd5;
   localparam logic [3:0] FX_UP        = 4'd6;
   localparam logic [3:0] FX_PORTA     = 4'd7;
   localparam logic [3:0] FX_VIBRATO   = 4'd8;
   localparam logic [3:0] FX_VIB_VOL   = 4'd9;
   localparam logic [3:0] FX_ARPEGGIO  = 4'd10;
   localparam logic [3:0] FX_PORTA_VOL = 4'd11;
   localparam logic [3:0] FX_OFFSET    = 4'd12;
   localparam logic [3:0] FX_TEMPO     = 4'd13;

   localparam logic [7:0] CMD_SPEED     = 8'd1;
   localparam logic [7:0] CMD_JUMP      = 8'd2;
   localparam logic [7:0] CMD_BREAK     = 8'd3;
   localparam logic [7:0] CMD_VOLSLIDE  = 8'd4;
   localparam logic [7:0] CMD_DOWN      = 8'd5;
   localparam logic [7:0] CMD_UP        = 8'd6;
   localparam logic [7:0] CMD_PORTA     = 8'd7;
   localparam logic [7:0] CMD_VIBRATO   = 8'd8;
   localparam logic [7:0] CMD_ARPEGGIO  = 8'd10;
   localparam logic [7:0] CMD_VIB_VOL   = 8'd11;
   localparam logic [7:0] CMD_PORTA_VOL = 8'd12;
   localparam logic [7:0] CMD_OFFSET    = 8'd15;
   localparam logic [7:0] CMD_TEMPO     = 8'd20;

   // Parse phase, one-hot.
   typedef enum logic [5:0] {
      PH_CONTROL = 6'b000001,
      PH_NOTE    = 6'b000010,
      PH_INST    = 6'b000100,
      PH_VOL     = 6'b001000,
      PH_CMD     = 6'b010000,
      PH_INFO    = 6'b100000
   } phase_type;

   function automatic logic [3:0] map_command(input logic [7:0] cmd);
      logic [3:0] code;
      begin
         unique case (cmd)
            CMD_SPEED:     code = FX_SPEED;
            CMD_JUMP:      code = FX_JUMP;
            CMD_BREAK:     code = FX_BREAK;
            CMD_VOLSLIDE:  code = FX_VOLSLIDE;
            CMD_DOWN:      code = FX_DOWN;
            CMD_UP:        code = FX_UP;
            CMD_PORTA:     code = FX_PORTA;
            CMD_VIBRATO:   code = FX_VIBRATO;
            CMD_VIB_VOL:   code = FX_VIB_VOL;
            CMD_ARPEGGIO:  code = FX_ARPEGGIO;
            CMD_PORTA_VOL: code = FX_PORTA_VOL;
            CMD_OFFSET:    code = FX_OFFSET;
            CMD_TEMPO:     code = FX_TEMPO;
            default:       code = FX_NONE;
         endcase
         return code;
      end
   endfunction

   // Two BCD digits to binary: hi*10 + lo, at most 165.
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] bcd);
      logic [7:0] hi;
      logic [7:0] lo;
      begin
         hi = {4'd0, bcd[7:4]};
         lo = {4'd0, bcd[3:0]};
         return (hi << 3) + (hi << 1) + lo;
      end
   endfunction

endpackage

>>> rtl/packed_pattern_row_decoder.sv
// Top level of the packed pattern row decoder: byte parser and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  req     | in        | req_valid/req_stall  | data_byte, pattern_start
//  rsp     | out       | rsp_valid/rsp_stall  | channel, row, note, instrument, volume, fx
//
// One byte per cycle: each accepted byte updates the parse phase and the held
// fields in the same cycle, and a completed entry lands in the result register.
// A new byte is taken while the result register is empty or being drained, so
// the input only stalls when a finished entry waits under rsp_stall.
// Reset (synchronous) returns the parser to expecting a control byte at row zero
// and empties the result register.
module packed_pattern_row_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_pattern_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_channel,
   output logic [5:0] rsp_row,
   output logic [1:0] rsp_note_kind,
   output logic [3:0] rsp_note_value,
   output logic [4:0] rsp_octave,
   output logic       rsp_has_instrument,
   output logic [7:0] rsp_instrument,
   output logic       rsp_has_volume,
   output logic [7:0] rsp_volume,
   output logic [3:0] rsp_effect_code,
   output logic [7:0] rsp_effect_info
);
   import pprd_pkg::*;

   // Parser state.
   phase_type              phase_ff, phase_in;
   logic [ROW_COUNT_W-1:0] row_count_ff, row_count_in;
   logic [7:0]             held_control_ff, held_control_in;
   logic [7:0]             held_note_ff, held_note_in;
   logic [7:0]             held_inst_ff, held_inst_in;
   logic [7:0]             held_vol_ff, held_vol_in;
   logic [7:0]             held_cmd_ff, held_cmd_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] rsp_channel_ff, rsp_channel_in;
   logic [5:0] rsp_row_ff, rsp_row_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [3:0] rsp_nv_ff, rsp_nv_in;
   logic [4:0] rsp_oct_ff, rsp_oct_in;
   logic       rsp_has_inst_ff, rsp_has_inst_in;
   logic [7:0] rsp_inst_ff, rsp_inst_in;
   logic       rsp_has_vol_ff, rsp_has_vol_in;
   logic [7:0] rsp_vol_ff, rsp_vol_in;
   logic [3:0] rsp_code_ff, rsp_code_in;
   logic [7:0] rsp_info_ff, rsp_info_in;

   logic                   accept;
   phase_type              phase_cur;
   logic [ROW_COUNT_W-1:0] row_cur;
   logic                   emit;
   logic [7:0]             ctl_eff;
   logic [7:0]             inst_eff;
   logic [7:0]             vol_eff;
   logic [7:0]             info_eff;
   logic [3:0]             fx_code;

   // Take a transaction unless a finished entry is held under stall.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Pattern start restarts the row and the phase before the byte is parsed.
   assign phase_cur = req_pattern_start ? PH_CONTROL : phase_ff;
   assign row_cur   = req_pattern_start ? '0 : row_count_ff;

   always_comb begin
      phase_in        = phase_ff;
      row_count_in    = row_count_ff;
      held_control_in = held_control_ff;
      held_note_in    = held_note_ff;
      held_inst_in    = held_inst_ff;
      held_vol_in     = held_vol_ff;
      held_cmd_in     = held_cmd_ff;
      emit            = 1'b0;
      ctl_eff         = held_control_ff;
      inst_eff        = held_inst_ff;
      vol_eff         = held_vol_ff;
      info_eff        = 8'd0;

      if (accept) begin
         row_count_in = row_cur;
         phase_in     = phase_cur;
         if (row_cur >= ROWS_PER_PATTERN) begin
            // Past the last row: drop everything until the next pattern.
            phase_in = PH_CONTROL;
         end else begin
            unique case (phase_cur)
               PH_CONTROL: begin
                  if (req_data_byte == 8'd0) begin
                     row_count_in = row_cur + ROW_COUNT_W'(1);
                  end else begin
                     held_control_in = req_data_byte;
                     ctl_eff         = req_data_byte;
                     if (req_data_byte[CTL_BIT_NOTE]) phase_in = PH_NOTE;
                     else if (req_data_byte[CTL_BIT_VOL]) phase_in = PH_VOL;
                     else if (req_data_byte[CTL_BIT_CMD]) phase_in = PH_CMD;
                     else begin
                        phase_in = PH_CONTROL;
                        emit     = 1'b1;
                     end
                  end
               end
               PH_NOTE: begin
                  held_note_in = req_data_byte;
                  phase_in     = PH_INST;
               end
               PH_INST: begin
                  held_inst_in = req_data_byte;
                  inst_eff     = req_data_byte;
                  if (held_control_ff[CTL_BIT_VOL]) phase_in = PH_VOL;
                  else if (held_control_ff[CTL_BIT_CMD]) phase_in = PH_CMD;
                  else begin
                     phase_in = PH_CONTROL;
                     emit     = 1'b1;
                  end
               end
               PH_VOL: begin
                  held_vol_in = req_data_byte;
                  vol_eff     = req_data_byte;
                  if (held_control_ff[CTL_BIT_CMD]) phase_in = PH_CMD;
                  else begin
                     phase_in = PH_CONTROL;
                     emit     = 1'b1;
                  end
               end
               PH_CMD: begin
                  held_cmd_in = req_data_byte;
                  phase_in    = PH_INFO;
               end
               PH_INFO: begin
                  info_eff = req_data_byte;
                  phase_in = PH_CONTROL;
                  emit     = 1'b1;
               end
               default: begin
                  phase_in = PH_CONTROL;
               end
            endcase
         end
      end
   end

   // Build the entry from the held fields and the byte that completes it.
   assign fx_code = ctl_eff[CTL_BIT_CMD] ? map_command(held_cmd_ff) : FX_NONE;

   always_comb begin
      rsp_kind_in = KIND_NONE;
      rsp_nv_in   = 4'd0;
      rsp_oct_in  = 5'd0;
      if (ctl_eff[CTL_BIT_NOTE]) begin
         if (held_note_ff == NOTE_KEY_OFF) begin
            rsp_kind_in = KIND_KEY_OFF;
         end else if (held_note_ff != NOTE_EMPTY) begin
            rsp_kind_in = KIND_NOTE;
            rsp_nv_in   = held_note_ff[3:0];
            rsp_oct_in  = {1'b0, held_note_ff[7:4]} + 5'd1;
         end
      end
      rsp_channel_in  = ctl_eff[4:0];
      rsp_row_in      = row_cur[5:0];
      rsp_has_inst_in = ctl_eff[CTL_BIT_NOTE];
      rsp_inst_in     = ctl_eff[CTL_BIT_NOTE] ? inst_eff : 8'd0;
      rsp_has_vol_in  = ctl_eff[CTL_BIT_VOL];
      rsp_vol_in      = ctl_eff[CTL_BIT_VOL] ? vol_eff : 8'd0;
      rsp_code_in     = fx_code;
      rsp_info_in     = (fx_code == FX_BREAK) ? bcd_to_bin(info_eff) : info_eff;
   end

   // Load on a new entry, drop once drained.
   always_comb begin
      if (accept) rsp_valid_in = emit;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_CONTROL;
         row_count_ff    <= '0;
         held_control_ff <= 8'd0;
         held_note_ff    <= 8'd0;
         held_inst_ff    <= 8'd0;
         held_vol_ff     <= 8'd0;
         held_cmd_ff     <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         row_count_ff    <= row_count_in;
         held_control_ff <= held_control_in;
         held_note_ff    <= held_note_in;
         held_inst_ff    <= held_inst_in;
         held_vol_ff     <= held_vol_in;
         held_cmd_ff     <= held_cmd_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_channel_ff  <= rsp_channel_in;
         rsp_row_ff      <= rsp_row_in;
         rsp_kind_ff     <= rsp_kind_in;
         rsp_nv_ff       <= rsp_nv_in;
         rsp_oct_ff      <= rsp_oct_in;
         rsp_has_inst_ff <= rsp_has_inst_in;
         rsp_inst_ff     <= rsp_inst_in;
         rsp_has_vol_ff  <= rsp_has_vol_in;
         rsp_vol_ff      <= rsp_vol_in;
         rsp_code_ff     <= rsp_code_in;
         rsp_info_ff     <= rsp_info_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel        = rsp_channel_ff;
   assign rsp_row            = rsp_row_ff;
   assign rsp_note_kind      = rsp_kind_ff;
   assign rsp_note_value     = rsp_nv_ff;
   assign rsp_octave         = rsp_oct_ff;
   assign rsp_has_instrument = rsp_has_inst_ff;
   assign rsp_instrument     = rsp_inst_ff;
   assign rsp_has_volume     = rsp_has_vol_ff;
   assign rsp_volume         = rsp_vol_ff;
   assign rsp_effect_code    = rsp_code_ff;
   assign rsp_effect_info    = rsp_info_ff;

   // The row counter never runs past the pattern end.
   a_row_bounded: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= ROWS_PER_PATTERN)
      else $error("row counter past pattern end");

   // A row-ending byte at pattern start lands on row one.
   a_start_row_end: assert property (@(posedge clock) disable iff (reset)
      accept && req_pattern_start && (req_data_byte == 8'd0) |=> row_count_ff == 7'd1)
      else $error("pattern start did not restart the row count");

   // Only completing phases produce an entry.
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      accept && emit && !req_pattern_start |->
         (phase_ff == PH_CONTROL) || (phase_ff == PH_INST) ||
         (phase_ff == PH_VOL) || (phase_ff == PH_INFO))
      else $error("entry emitted from a non-final phase");

   // A present note carries an instrument and a nonzero octave.
   a_note_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_NOTE) |-> rsp_has_inst_ff && (rsp_oct_ff != 5'd0))
      else $error("note entry missing instrument or octave");

   // A held entry is not overwritten while stalled.
   a_hold_under_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_info_ff) && $stable(rsp_row_ff))
      else $error("stalled entry changed");

endmodule

>>> bench/tb.sv
// Self-checking bench for the packed pattern row decoder: random byte streams, predicted entries.
`timescale 1ns / 1ps

module tb;
   import pprd_pkg::*;

   // One decoded pattern entry, laid out like the result ports.
   typedef struct packed {
      logic [4:0] channel;
      logic [5:0] row;
      logic [1:0] note_kind;
      logic [3:0] note_value;
      logic [4:0] octave;
      logic       has_instrument;
      logic [7:0] instrument;
      logic       has_volume;
      logic [7:0] volume;
      logic [3:0] effect_code;
      logic [7:0] effect_info;
   } row_entry_type;

   // One byte waiting to go out, with the idle cycles that follow it.
   typedef struct packed {
      logic [7:0] data;
      logic       start;
      int         gap;
   } stream_byte_type;

   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 20;
   localparam int PRINT_LIMIT = 200;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_pattern_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [4:0] rsp_channel;
   logic [5:0] rsp_row;
   logic [1:0] rsp_note_kind;
   logic [3:0] rsp_note_value;
   logic [4:0] rsp_octave;
   logic       rsp_has_instrument;
   logic [7:0] rsp_instrument;
   logic       rsp_has_volume;
   logic [7:0] rsp_volume;
   logic [3:0] rsp_effect_code;
   logic [7:0] rsp_effect_info;

   packed_pattern_row_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_pattern_start  (req_pattern_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_channel        (rsp_channel),
      .rsp_row            (rsp_row),
      .rsp_note_kind      (rsp_note_kind),
      .rsp_note_value     (rsp_note_value),
      .rsp_octave         (rsp_octave),
      .rsp_has_instrument (rsp_has_instrument),
      .rsp_instrument     (rsp_instrument),
      .rsp_has_volume     (rsp_has_volume),
      .rsp_volume         (rsp_volume),
      .rsp_effect_code    (rsp_effect_code),
      .rsp_effect_info    (rsp_effect_info)
   );

   always #10 clock = ~clock;

   // Stimulus and scoreboard storage.
   stream_byte_type pending_bytes[$];
   row_entry_type   expected_entries[$];
   int              bytes_queued   = 0;
   int              bytes_accepted = 0;
   int              mismatch_count = 0;

   // Stimulus shaping: start flag for the next queued byte, and quiet stretches.
   logic start_next = 1'b0;
   logic quiet_req  = 1'b0;
   logic quiet_rsp  = 1'b0;

   // Decoder shadow state.
   phase_type                 parse_phase = PH_CONTROL;
   logic [ROW_COUNT_W-1:0]    row_count   = '0;
   logic [7:0]                held_control    = 8'd0;
   logic [7:0]                held_note       = 8'd0;
   logic [7:0]                held_instrument = 8'd0;
   logic [7:0]                held_volume     = 8'd0;
   logic [7:0]                held_command    = 8'd0;

   // Print one mismatch line (up to a cap) and count it.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("tb: mismatch at %0t: %s", $realtime, what);
   endtask

   // Command letter to dense effect code; unknown letters give no effect.
   function automatic logic [3:0] effect_for(input logic [7:0] cmd);
      case (cmd)
         CMD_SPEED:     return FX_SPEED;
         CMD_JUMP:      return FX_JUMP;
         CMD_BREAK:     return FX_BREAK;
         CMD_VOLSLIDE:  return FX_VOLSLIDE;
         CMD_DOWN:      return FX_DOWN;
         CMD_UP:        return FX_UP;
         CMD_PORTA:     return FX_PORTA;
         CMD_VIBRATO:   return FX_VIBRATO;
         CMD_VIB_VOL:   return FX_VIB_VOL;
         CMD_ARPEGGIO:  return FX_ARPEGGIO;
         CMD_PORTA_VOL: return FX_PORTA_VOL;
         CMD_OFFSET:    return FX_OFFSET;
         CMD_TEMPO:     return FX_TEMPO;
         default:       return FX_NONE;
      endcase
   endfunction

   // Next field group named by the held control byte once 'done' groups are read
   // (0 after control, 1 after note/instrument, 2 after volume).
   function automatic phase_type phase_after(input int done);
      if (done < 1 && held_control[CTL_BIT_NOTE]) return PH_NOTE;
      if (done < 2 && held_control[CTL_BIT_VOL])  return PH_VOL;
      if (done < 3 && held_control[CTL_BIT_CMD])  return PH_CMD;
      return PH_CONTROL;
   endfunction

   // Build the entry from the held fields and queue it as expected.
   task automatic log_entry(input logic [7:0] info);
      row_entry_type e;
      e.channel        = held_control[4:0];
      e.row            = row_count[5:0];
      e.note_kind      = KIND_NONE;
      e.note_value     = 4'd0;
      e.octave         = 5'd0;
      e.has_instrument = held_control[CTL_BIT_NOTE];
      e.instrument     = held_control[CTL_BIT_NOTE] ? held_instrument : 8'd0;
      e.has_volume     = held_control[CTL_BIT_VOL];
      e.volume         = held_control[CTL_BIT_VOL] ? held_volume : 8'd0;
      e.effect_code    = FX_NONE;
      e.effect_info    = 8'd0;
      if (held_control[CTL_BIT_NOTE]) begin
         if (held_note == NOTE_KEY_OFF) begin
            e.note_kind = KIND_KEY_OFF;
         end else if (held_note != NOTE_EMPTY) begin
            e.note_kind  = KIND_NOTE;
            e.note_value = held_note[3:0];
            e.octave     = {1'b0, held_note[7:4]} + 5'd1;
         end
      end
      if (held_control[CTL_BIT_CMD]) begin
         e.effect_code = effect_for(held_command);
         e.effect_info = info;
         // Break-to-row carries its row as two BCD digits.
         if (e.effect_code == FX_BREAK)
            e.effect_info = {4'd0, info[7:4]} * 8'd10 + {4'd0, info[3:0]};
      end
      expected_entries.push_back(e);
   endtask

   // Advance the shadow parser by one accepted byte.
   task automatic decode_byte(input logic [7:0] b, input logic start);
      if (start) begin
         row_count   = '0;
         parse_phase = PH_CONTROL;
      end
      // Past the last row: ignore everything until the next pattern start.
      if (row_count >= ROWS_PER_PATTERN) begin
         parse_phase = PH_CONTROL;
         return;
      end
      case (parse_phase)
         PH_CONTROL: begin
            if (b == 8'd0) begin
               row_count = row_count + ROW_COUNT_W'(1);
            end else begin
               held_control = b;
               parse_phase  = phase_after(0);
               if (parse_phase == PH_CONTROL) log_entry(8'd0);
            end
         end
         PH_NOTE: begin
            held_note   = b;
            parse_phase = PH_INST;
         end
         PH_INST: begin
            held_instrument = b;
            parse_phase     = phase_after(1);
            if (parse_phase == PH_CONTROL) log_entry(8'd0);
         end
         PH_VOL: begin
            held_volume = b;
            parse_phase = phase_after(2);
            if (parse_phase == PH_CONTROL) log_entry(8'd0);
         end
         PH_CMD: begin
            held_command = b;
            parse_phase  = PH_INFO;
         end
         PH_INFO: begin
            parse_phase = PH_CONTROL;
            log_entry(b);
         end
         default: parse_phase = PH_CONTROL;
      endcase
   endtask

   // Queue one byte; the pattern start flag is consumed by the first byte after it is set.
   task automatic push_byte(input logic [7:0] b);
      stream_byte_type sb;
      sb.data  = b;
      sb.start = start_next;
      sb.gap   = quiet_req ? 0 : $urandom_range(0, 6);
      start_next = 1'b0;
      pending_bytes.push_back(sb);
      bytes_queued++;
   endtask

   // Mostly real command letters, now and then an arbitrary byte.
   function automatic logic [7:0] pick_command();
      case ($urandom_range(0, 15))
         0:       return CMD_SPEED;
         1:       return CMD_JUMP;
         2:       return CMD_BREAK;
         3:       return CMD_VOLSLIDE;
         4:       return CMD_DOWN;
         5:       return CMD_UP;
         6:       return CMD_PORTA;
         7:       return CMD_VIBRATO;
         8:       return CMD_VIB_VOL;
         9:       return CMD_ARPEGGIO;
         10:      return CMD_PORTA_VOL;
         11:      return CMD_OFFSET;
         12:      return CMD_TEMPO;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Queue a complete entry with random content for the fields the control byte names.
   task automatic push_entry(input logic [7:0] ctl);
      int pick;
      push_byte(ctl);
      if (ctl[CTL_BIT_NOTE]) begin
         pick = $urandom_range(0, 7);
         if (pick == 0)      push_byte(NOTE_KEY_OFF);
         else if (pick == 1) push_byte(NOTE_EMPTY);
         else                push_byte(8'($urandom_range(0, 255)));
         push_byte(8'($urandom_range(0, 255)));
      end
      if (ctl[CTL_BIT_VOL]) push_byte(8'($urandom_range(0, 255)));
      if (ctl[CTL_BIT_CMD]) begin
         push_byte(pick_command());
         push_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Stimulus: directed corners first, then random patterns; then wait for the drain.
   initial begin
      int kind;
      int rows;

      // Directed: every field, octave 16, BCD break 99, on a pattern start.
      start_next = 1'b1;
      push_byte(8'hE5);
      push_byte(8'hFB);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(CMD_BREAK);
      push_byte(8'h99);
      // Control byte with no fields: emit at once, channel 31.
      push_byte(8'h1F);
      // Key off on channel 0, instrument 0.
      push_byte(8'h20);
      push_byte(NOTE_KEY_OFF);
      push_byte(8'h00);
      // Empty note with volume.
      push_byte(8'h6A);
      push_byte(NOTE_EMPTY);
      push_byte(8'h01);
      push_byte(8'hFF);
      // Unknown command keeps its info byte.
      push_byte(8'h81);
      push_byte(8'hFF);
      push_byte(8'hA5);
      // End of row.
      push_byte(8'h00);
      // Truncated entry: a pattern start in the middle drops it.
      push_byte(8'hC3);
      push_byte(8'h00);
      start_next = 1'b1;
      push_byte(8'h40);
      push_byte(8'h80);
      // Tempo at its top info value.
      push_byte(8'h9E);
      push_byte(CMD_TEMPO);
      push_byte(8'hFF);

      // Random patterns: mostly well-formed, some full-length, some noise.
      while (bytes_queued < 1050) begin
         quiet_req  = ($urandom_range(0, 4) == 0);
         start_next = 1'b1;
         kind       = $urandom_range(0, 19);
         if (kind == 0) begin
            // Run a pattern to its last row, then feed bytes that must be ignored.
            for (int r = 0; r < ROWS_PER_PATTERN; r++) begin
               if ($urandom_range(0, 3) == 0) push_entry(8'($urandom_range(1, 255)));
               push_byte(8'd0);
            end
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
         end else if (kind <= 2) begin
            // Noise with stray pattern starts.
            push_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(4, 20)) begin
               start_next = ($urandom_range(0, 7) == 0);
               push_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            rows = $urandom_range(1, 6);
            for (int r = 0; r < rows; r++) begin
               repeat ($urandom_range(0, 3)) push_entry(8'($urandom_range(1, 255)));
               push_byte(8'd0);
            end
            // Leave an entry half sent; the next pattern start cuts it off.
            if ($urandom_range(0, 5) == 0) begin
               push_byte(8'hE0 | 8'($urandom_range(0, 31)));
               push_byte(8'($urandom_range(0, 255)));
            end
         end
      end

      // Hold reset, then release it on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every byte to go in and every entry to come out, then drain.
      while (bytes_accepted != bytes_queued || expected_entries.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Driver, sample side: a transaction is taken at a rising edge with valid
   // high and stall low; feed it to the shadow parser right there.
   logic byte_taken = 1'b0;
   int   gap_left   = 0;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         decode_byte(req_data_byte, req_pattern_start);
         bytes_accepted++;
         byte_taken = 1'b1;
      end
   end

   // Driver, drive side: on the falling edge hold a stalled byte, otherwise
   // idle out the drawn gap and then present the next pending byte.
   always @(negedge clock) begin
      stream_byte_type sb;
      if (!reset && (byte_taken || !req_valid)) begin
         byte_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            sb = pending_bytes.pop_front();
            gap_left = sb.gap;
            req_valid         <= 1'b1;
            req_data_byte     <= sb.data;
            req_pattern_start <= sb.start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each taken result against the oldest expected entry.
   row_entry_type want;
   int            stall_left = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_entries.size() == 0) begin
            report_mismatch($sformatf("unexpected entry ch %0d row %0d",
                                      rsp_channel, rsp_row));
         end else begin
            want = expected_entries.pop_front();
            if (rsp_channel !== want.channel)
               report_mismatch($sformatf("channel %0d, want %0d", rsp_channel, want.channel));
            if (rsp_row !== want.row)
               report_mismatch($sformatf("row %0d, want %0d", rsp_row, want.row));
            if (rsp_note_kind !== want.note_kind)
               report_mismatch($sformatf("note_kind %0d, want %0d",
                                         rsp_note_kind, want.note_kind));
            if (rsp_note_value !== want.note_value)
               report_mismatch($sformatf("note_value %0d, want %0d",
                                         rsp_note_value, want.note_value));
            if (rsp_octave !== want.octave)
               report_mismatch($sformatf("octave %0d, want %0d", rsp_octave, want.octave));
            if (rsp_has_instrument !== want.has_instrument)
               report_mismatch($sformatf("has_instrument %0d, want %0d",
                                         rsp_has_instrument, want.has_instrument));
            if (rsp_instrument !== want.instrument)
               report_mismatch($sformatf("instrument %0d, want %0d",
                                         rsp_instrument, want.instrument));
            if (rsp_has_volume !== want.has_volume)
               report_mismatch($sformatf("has_volume %0d, want %0d",
                                         rsp_has_volume, want.has_volume));
            if (rsp_volume !== want.volume)
               report_mismatch($sformatf("volume %0d, want %0d", rsp_volume, want.volume));
            if (rsp_effect_code !== want.effect_code)
               report_mismatch($sformatf("effect_code %0d, want %0d",
                                         rsp_effect_code, want.effect_code));
            if (rsp_effect_info !== want.effect_info)
               report_mismatch($sformatf("effect_info %0d, want %0d",
                                         rsp_effect_info, want.effect_info));
         end
         // Draw the stall before the next result; switch quiet stretches now and then.
         if ($urandom_range(0, 29) == 0) quiet_rsp = ~quiet_rsp;
         stall_left = quiet_rsp ? 0 : $urandom_range(0, 6);
      end
   end

   // Monitor stall: raise it while stall_left is above zero, counting it down, then drop it.
   always @(negedge clock) begin
      if (!reset && stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: end the run when no transaction moves on either side for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

endmodule
